// ----- rtl/glfdm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glfdm_pkg
// shared types, codes and fixed widths of the light and fuel distance map
// ----------------------------------------------------------------------------
package glfdm_pkg;

    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_LIGHT_REACH = 10;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 6;
    localparam int ITEM_W  = 2;
    localparam int DIM_W   = 7;
    localparam int LIGHT_W = 16;
    localparam int FUEL_W  = 8;

    // flat index: col + row * width stays below 2^14 for any 7-bit width
    localparam int IDX_W   = 14;
    // squared distance, distance and top square root bit
    localparam int D2_W    = 15;
    localparam int DIST_W  = 8;
    localparam int SQ_TOP  = 14;

    localparam logic [FUEL_W-1:0] NO_FUEL  = 8'hFF;
    localparam logic [FUEL_W-1:0] FUEL_CAP = 8'd127;

    typedef enum logic [CMD_W-1:0] {
        CMD_PLACE = 2'd0,
        CMD_BAKE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [ITEM_W-1:0] {
        ITEM_EMPTY = 2'd0,
        ITEM_FUEL  = 2'd1,
        ITEM_LIGHT = 2'd2,
        ITEM_STEP  = 2'd3
    } t_item;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg;

endpackage

// ----- rtl/glfdm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glfdm_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module glfdm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/grid_light_and_fuel_distance_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_light_and_fuel_distance_map
// grid of item codes with baked light levels and nearest fuel distances
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAX_WIDTH*MAX_HEIGHT cells to clear the
// three cell memories; no command beat is taken during that sweep,
// configuration writes are. A place writes the item memory on accept, a read
// goes through ST_READ for the registered memory read. A bake scans every cell
// in use for sources (ST_SRC_RD and ST_SRC_CHK, for the item read) and, for
// each light source or fuel station, walks every cell in use through ST_DIST
// for the squared distance, ST_SQRT for the bit-serial square root and ST_WB
// for the write back. Every command gives exactly one result beat; a result
// waiting in the output register blocks the next command only while the
// receiver stalls it.
// ----------------------------------------------------------------------------
module grid_light_and_fuel_distance_map #(
    parameter int LIGHT_REACH = glfdm_pkg::DEF_LIGHT_REACH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // command channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [glfdm_pkg::CMD_W-1:0]          i_command,
    input  logic [glfdm_pkg::COL_W-1:0]          i_col,
    input  logic [glfdm_pkg::ROW_W-1:0]          i_row,
    input  logic [glfdm_pkg::ITEM_W-1:0]         i_item_code,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_status,
    output logic [glfdm_pkg::ITEM_W-1:0]         o_cell_item,
    output logic [glfdm_pkg::LIGHT_W-1:0]        o_light_level,
    output logic signed [glfdm_pkg::FUEL_W-1:0]  o_fuel_distance,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [glfdm_pkg::DIM_W-1:0]          i_cfg_data
);

    // grid bounds are fixed by the package defaults
    localparam int MAX_WIDTH  = glfdm_pkg::DEF_MAX_WIDTH;
    localparam int MAX_HEIGHT = glfdm_pkg::DEF_MAX_HEIGHT;

    localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [8:0] REACH = 9'(LIGHT_REACH);

    localparam int DW = glfdm_pkg::DIM_W;
    localparam int IW = glfdm_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SRC_RD,
        ST_SRC_CHK,
        ST_DIST,
        ST_SQRT,
        ST_WB
    } t_state;

    t_state r_state;

    // configuration registers
    logic [DW-1:0] r_grid_width;
    logic [DW-1:0] r_grid_height;

    // clamped dimensions in use
    logic [DW-1:0] w_w;
    logic [DW-1:0] w_h;
    logic [IW-1:0] w_n;
    logic [IW-1:0] w_idx;
    logic          w_inside;

    // decoded command
    glfdm_pkg::t_cmd w_cmd;

    // bake walk
    logic [ADDR_W-1:0] r_clr;
    logic [IW-1:0]     r_s;
    logic [DW-1:0]     r_sx;
    logic [DW-1:0]     r_sy;
    logic [IW-1:0]     r_c;
    logic [DW-1:0]     r_cx;
    logic [DW-1:0]     r_cy;
    logic              r_src_light;
    logic              w_src;

    // square root unit
    logic [glfdm_pkg::D2_W-1:0] r_rem;
    logic [glfdm_pkg::D2_W-1:0] r_res;
    logic [glfdm_pkg::D2_W-1:0] r_bit;
    logic [glfdm_pkg::D2_W:0]   w_trial;
    logic [DW-1:0]              w_dx;
    logic [DW-1:0]              w_dy;
    logic [glfdm_pkg::D2_W-1:0] w_d2;

    // result register
    logic                           r_o_valid;
    logic                           n_o_valid;
    logic                           r_o_status;
    logic [glfdm_pkg::ITEM_W-1:0]   r_o_item;
    logic [glfdm_pkg::LIGHT_W-1:0]  r_o_light;
    logic [glfdm_pkg::FUEL_W-1:0]   r_o_fuel;

    logic w_out_free;
    logic w_in_acc;

    // memory ports
    logic                          w_it_we, w_it_re, w_lt_we, w_lt_re;
    logic [ADDR_W-1:0]             w_it_waddr, w_it_raddr, w_lt_waddr, w_lt_raddr;
    logic [glfdm_pkg::ITEM_W-1:0]  w_it_wdata, w_it_rdata;
    logic [glfdm_pkg::LIGHT_W-1:0] w_lt_wdata, w_lt_rdata;
    logic [glfdm_pkg::FUEL_W-1:0]  w_fu_wdata, w_fu_rdata;

    // write-back values
    logic [glfdm_pkg::DIST_W-1:0]  w_d;
    logic [8:0]                    w_gain;
    logic [glfdm_pkg::LIGHT_W:0]   w_sum;
    logic [glfdm_pkg::LIGHT_W-1:0] w_new_light;
    logic [glfdm_pkg::FUEL_W-1:0]  w_dd;
    logic [glfdm_pkg::FUEL_W-1:0]  w_new_fuel;

    // last cell / last source of the walk
    logic w_s_last;
    logic w_c_last;

    // ---------------------------------------------------------------- dims
    // zero reads as one, anything above the maximum reads as the maximum
    always_comb begin
        if (r_grid_width == '0) begin
            w_w = DW'(1);
        end else if ({2'b00, r_grid_width} > 9'(MAX_WIDTH)) begin
            w_w = DW'(MAX_WIDTH);
        end else begin
            w_w = r_grid_width;
        end
        if (r_grid_height == '0) begin
            w_h = DW'(1);
        end else if ({2'b00, r_grid_height} > 9'(MAX_HEIGHT)) begin
            w_h = DW'(MAX_HEIGHT);
        end else begin
            w_h = r_grid_height;
        end
    end

    assign w_n      = IW'(w_w) * IW'(w_h);
    assign w_idx    = IW'(i_col) + IW'(i_row) * IW'(w_w);
    assign w_inside = (w_idx < w_n);
    assign w_cmd    = glfdm_pkg::t_cmd'(i_command);

    assign w_s_last = (r_s == w_n - IW'(1));
    assign w_c_last = (r_c == w_n - IW'(1));

    assign w_src = (w_it_rdata == glfdm_pkg::ITEM_FUEL) ||
                   (w_it_rdata == glfdm_pkg::ITEM_LIGHT);

    // ---------------------------------------------------------------- handshake
    assign w_out_free  = !r_o_valid || !i_stall;
    assign o_stall     = !((r_state == ST_IDLE) && w_out_free);
    assign w_in_acc    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // result slot: held while stalled, filled when a command finishes
    always_comb begin
        n_o_valid = r_o_valid && i_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_cmd != glfdm_pkg::CMD_BAKE &&
                    !(w_cmd == glfdm_pkg::CMD_READ && w_inside)) begin
                    n_o_valid = 1'b1;
                end
            end
            ST_READ: begin
                n_o_valid = 1'b1;
            end
            ST_SRC_CHK: begin
                if (!w_src && w_s_last) begin
                    n_o_valid = 1'b1;
                end
            end
            ST_WB: begin
                if (w_c_last && w_s_last) begin
                    n_o_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- distance
    assign w_dx = (r_sx > r_cx) ? r_sx - r_cx : r_cx - r_sx;
    assign w_dy = (r_sy > r_cy) ? r_sy - r_cy : r_cy - r_sy;
    assign w_d2 = glfdm_pkg::D2_W'(w_dx) * glfdm_pkg::D2_W'(w_dx) +
                  glfdm_pkg::D2_W'(w_dy) * glfdm_pkg::D2_W'(w_dy);

    // one result bit per cycle
    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};

    assign w_d    = r_res[glfdm_pkg::DIST_W-1:0];
    assign w_gain = REACH - {1'b0, w_d};
    assign w_sum  = {1'b0, w_lt_rdata} + 17'(w_gain);

    always_comb begin
        w_new_light = w_lt_rdata;
        if ({1'b0, w_d} < REACH) begin
            w_new_light = w_sum[glfdm_pkg::LIGHT_W] ? '1 : w_sum[glfdm_pkg::LIGHT_W-1:0];
        end
        w_dd       = (w_d > glfdm_pkg::FUEL_CAP) ? glfdm_pkg::FUEL_CAP : w_d;
        w_new_fuel = w_fu_rdata;
        if (w_fu_rdata == glfdm_pkg::NO_FUEL || w_fu_rdata > w_dd) begin
            w_new_fuel = w_dd;
        end
    end

    // ---------------------------------------------------------------- memory control
    always_comb begin
        w_it_we    = 1'b0;
        w_it_waddr = ADDR_W'(w_idx);
        w_it_wdata = i_item_code;
        w_it_re    = 1'b0;
        w_it_raddr = ADDR_W'(w_idx);
        w_lt_we    = 1'b0;
        w_lt_waddr = ADDR_W'(r_c);
        w_lt_wdata = w_new_light;
        w_fu_wdata = w_new_fuel;
        w_lt_re    = 1'b0;
        w_lt_raddr = ADDR_W'(w_idx);
        unique case (r_state)
            ST_CLEAR: begin
                w_it_we    = 1'b1;
                w_it_waddr = r_clr;
                w_it_wdata = glfdm_pkg::ITEM_EMPTY;
                w_lt_we    = 1'b1;
                w_lt_waddr = r_clr;
                w_lt_wdata = '0;
                w_fu_wdata = glfdm_pkg::NO_FUEL;
            end
            ST_IDLE: begin
                if (w_in_acc && w_inside) begin
                    w_it_we = (w_cmd == glfdm_pkg::CMD_PLACE);
                    w_it_re = (w_cmd == glfdm_pkg::CMD_READ);
                    w_lt_re = (w_cmd == glfdm_pkg::CMD_READ);
                end
            end
            ST_SRC_RD: begin
                w_it_re    = 1'b1;
                w_it_raddr = ADDR_W'(r_s);
            end
            ST_DIST: begin
                w_lt_re    = 1'b1;
                w_lt_raddr = ADDR_W'(r_c);
            end
            ST_WB: begin
                // light cells only change for light sources, fuel for stations
                w_lt_we = 1'b1;
                if (r_src_light) begin
                    w_fu_wdata = w_fu_rdata;
                end else begin
                    w_lt_wdata = w_lt_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr         <= '0;
            r_grid_width  <= DW'(64);
            r_grid_height <= DW'(64);
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (glfdm_pkg::t_reg'(i_cfg_index))
                    glfdm_pkg::REG_WIDTH:  r_grid_width  <= i_cfg_data;
                    glfdm_pkg::REG_HEIGHT: r_grid_height <= i_cfg_data;
                endcase
            end

            r_o_valid <= n_o_valid;

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == LAST_CELL) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        // place and read flag an address outside the grid in use
                        r_o_status <= (w_cmd == glfdm_pkg::CMD_PLACE ||
                                       w_cmd == glfdm_pkg::CMD_READ) && !w_inside;
                        r_o_item   <= '0;
                        r_o_light  <= '0;
                        r_o_fuel   <= (w_cmd == glfdm_pkg::CMD_READ && !w_inside) ?
                                      glfdm_pkg::NO_FUEL : '0;
                        unique case (w_cmd)
                            glfdm_pkg::CMD_READ: begin
                                if (w_inside) begin
                                    r_state <= ST_READ;
                                end
                            end
                            glfdm_pkg::CMD_BAKE: begin
                                r_s     <= '0;
                                r_sx    <= '0;
                                r_sy    <= '0;
                                r_state <= ST_SRC_RD;
                            end
                            glfdm_pkg::CMD_PLACE, glfdm_pkg::CMD_NONE: begin
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    // the slot was free at accept and only this block fills it
                    r_o_item  <= w_it_rdata;
                    r_o_light <= w_lt_rdata;
                    r_o_fuel  <= w_fu_rdata;
                    r_state   <= ST_IDLE;
                end
                ST_SRC_RD: begin
                    r_state <= ST_SRC_CHK;
                end
                ST_SRC_CHK: begin
                    if (w_src) begin
                        r_src_light <= (w_it_rdata == glfdm_pkg::ITEM_LIGHT);
                        r_c         <= '0;
                        r_cx        <= '0;
                        r_cy        <= '0;
                        r_state     <= ST_DIST;
                    end else if (w_s_last) begin
                        r_state   <= ST_IDLE;
                    end else begin
                        r_s <= r_s + IW'(1);
                        if (r_sx == w_w - DW'(1)) begin
                            r_sx <= '0;
                            r_sy <= r_sy + DW'(1);
                        end else begin
                            r_sx <= r_sx + DW'(1);
                        end
                        r_state <= ST_SRC_RD;
                    end
                end
                ST_DIST: begin
                    r_rem   <= w_d2;
                    r_res   <= '0;
                    r_bit   <= glfdm_pkg::D2_W'(1) << glfdm_pkg::SQ_TOP;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    if ({1'b0, r_rem} >= w_trial) begin
                        r_rem <= r_rem - w_trial[glfdm_pkg::D2_W-1:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    if (!w_c_last) begin
                        r_c <= r_c + IW'(1);
                        if (r_cx == w_w - DW'(1)) begin
                            r_cx <= '0;
                            r_cy <= r_cy + DW'(1);
                        end else begin
                            r_cx <= r_cx + DW'(1);
                        end
                        r_state <= ST_DIST;
                    end else if (w_s_last) begin
                        r_state   <= ST_IDLE;
                    end else begin
                        r_s <= r_s + IW'(1);
                        if (r_sx == w_w - DW'(1)) begin
                            r_sx <= '0;
                            r_sy <= r_sy + DW'(1);
                        end else begin
                            r_sx <= r_sx + DW'(1);
                        end
                        r_state <= ST_SRC_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // bake result can only be posted when the slot is free: the slot was free
    // at accept and nothing else fills it while the bake runs

    // ---------------------------------------------------------------- memories
    glfdm_ram #(
        .WIDTH (glfdm_pkg::ITEM_W),
        .DEPTH (CELLS),
        .ADDR_W(ADDR_W)
    ) u_items (
        .i_clk  (i_clk),
        .i_we   (w_it_we),
        .i_waddr(w_it_waddr),
        .i_wdata(w_it_wdata),
        .i_re   (w_it_re),
        .i_raddr(w_it_raddr),
        .o_rdata(w_it_rdata)
    );

    glfdm_ram #(
        .WIDTH (glfdm_pkg::LIGHT_W),
        .DEPTH (CELLS),
        .ADDR_W(ADDR_W)
    ) u_light (
        .i_clk  (i_clk),
        .i_we   (w_lt_we),
        .i_waddr(w_lt_waddr),
        .i_wdata(w_lt_wdata),
        .i_re   (w_lt_re),
        .i_raddr(w_lt_raddr),
        .o_rdata(w_lt_rdata)
    );

    // fuel shares the light ports: same address on every access
    glfdm_ram #(
        .WIDTH (glfdm_pkg::FUEL_W),
        .DEPTH (CELLS),
        .ADDR_W(ADDR_W)
    ) u_fuel (
        .i_clk  (i_clk),
        .i_we   (w_lt_we),
        .i_waddr(w_lt_waddr),
        .i_wdata(w_fu_wdata),
        .i_re   (w_lt_re),
        .i_raddr(w_lt_raddr),
        .o_rdata(w_fu_rdata)
    );

    // ---------------------------------------------------------------- outputs
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_cell_item     = r_o_item;
    assign o_light_level   = r_o_light;
    assign o_fuel_distance = signed'(r_o_fuel);

    // ---------------------------------------------------------------- checks
    a_no_cmd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> o_stall)
        else $error("command taken during clearing sweep");

    a_cell_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lt_we |-> (r_state == ST_CLEAR || r_state == ST_WB))
        else $error("light/fuel write outside clear or write back");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_command == glfdm_pkg::CMD_READ && w_inside)
        |=> (r_state == ST_READ))
        else $error("in-range read did not enter response state");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> $onehot(r_bit))
        else $error("square root step marker lost");

    a_bake_holds_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIST || r_state == ST_SQRT || r_state == ST_WB)
        |-> !(r_o_valid && $past(r_state) != ST_IDLE && !$past(r_o_valid)))
        else $error("result posted in the middle of a bake");

endmodule
